FILE: rtl/core/mcst_pkg.sv
package mcst_pkg;

    localparam int CHANNELS     = 16;
    localparam int NOTES        = 128;
    localparam int TABLE_DEPTH  = CHANNELS * NOTES;
    localparam int TABLE_ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CH_W         = $clog2(CHANNELS);
    localparam int DATA_W       = 7;
    localparam int VALUE_W      = 2 * DATA_W;
    localparam int QUEUE_DEPTH  = 2;

    // Command codes.
    localparam logic [1:0] CMD_MESSAGE = 2'd0;
    localparam logic [1:0] CMD_WATCH   = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // Message type nibbles.
    localparam logic [3:0] MT_NOTE_OFF = 4'h8;
    localparam logic [3:0] MT_NOTE_ON  = 4'h9;
    localparam logic [3:0] MT_CONTROL  = 4'hB;
    localparam logic [3:0] MT_PROGRAM  = 4'hC;
    localparam logic [3:0] MT_BEND     = 4'hE;

    // Address kinds.
    localparam logic [3:0] KIND_NOTE_ON   = 4'd0;
    localparam logic [3:0] KIND_NOTE_OFF  = 4'd1;
    localparam logic [3:0] KIND_CONTROL   = 4'd2;
    localparam logic [3:0] KIND_PROGRAM   = 4'd3;
    localparam logic [3:0] KIND_BEND      = 4'd4;
    localparam logic [3:0] KIND_TRIGGER   = 4'd5;
    localparam logic [3:0] KIND_LAST_ON   = 4'd6;
    localparam logic [3:0] KIND_LAST_OFF  = 4'd7;
    localparam logic [3:0] KIND_LAST_CTRL = 4'd8;

    typedef enum logic [2:0] {
        OP_NOTE_ON  = 3'd0,
        OP_NOTE_OFF = 3'd1,
        OP_CONTROL  = 3'd2,
        OP_PROGRAM  = 3'd3,
        OP_BEND     = 3'd4,
        OP_WATCH    = 3'd5,
        OP_READ     = 3'd6
    } t_op_code;

    // One classified operation as it travels from the front to the back.
    typedef struct packed {
        t_op_code          op;
        logic [CH_W-1:0]   ch;      // channel index 0..15
        logic [4:0]        chan;    // channel as reported in a result
        logic [3:0]        kind;    // result kind or watch/read kind
        logic [DATA_W-1:0] num;     // note, controller or program number
        logic [DATA_W-1:0] val;     // second data byte
        logic              flag;    // watch bit value, or read is supported
    } t_op_item;

endpackage

FILE: rtl/core/midi_channel_state_tracker.sv
// An accepted item passes the queue, then the registered table read and operation,
// then the output register. A message or read holds the back end in its response
// state, whether or not a result follows; a watch item skips that state.
// Reset: synchronous, active low; afterwards a pass over every table address clears
// the note, controller and watch tables, and no item is accepted until it finishes.
//
// The block mirrors the state of the sixteen MIDI channels. The front end
// accepts every item while its queue has room, classifies it by command and
// message type, drops items that change nothing (unknown message types, unused
// commands, watch items with a bad channel or kind) and places the rest into a
// two-entry queue. The back end takes one operation at a time from that queue.
// On a pop it writes the level or watch tables and the per-channel registers and
// issues a read of all tables at the same address; in the response state that
// follows, the registered read data decides whether a message notifies and
// supplies the value of a read. Results go through an output register, so the
// back end only stalls when that register is still full and a new result is ready.
module midi_channel_state_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_status_byte,
    input  logic [6:0]  i_data_one,
    input  logic [6:0]  i_data_two,
    input  logic [3:0]  i_kind,
    input  logic [4:0]  i_channel,
    input  logic [6:0]  i_number,
    input  logic        i_watch_enable,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic [3:0]  o_kind_res,
    output logic [4:0]  o_channel_res,
    output logic [6:0]  o_number_res,
    output logic [13:0] o_value
);

    // Queue handshake between the front end and the back end.
    logic               op_valid;
    logic               op_pop;
    mcst_pkg::t_op_item op;
    // High while the back end sweeps the tables after reset.
    logic               clearing;

    mcst_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clearing     (clearing),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_status_byte  (i_status_byte),
        .i_data_one     (i_data_one),
        .i_data_two     (i_data_two),
        .i_kind         (i_kind),
        .i_channel      (i_channel),
        .i_number       (i_number),
        .i_watch_enable (i_watch_enable),
        .o_op_valid     (op_valid),
        .o_op           (op),
        .i_pop          (op_pop)
    );

    mcst_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .o_clearing     (clearing),
        .i_op_valid     (op_valid),
        .i_op           (op),
        .o_pop          (op_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ok           (o_ok),
        .o_kind_res     (o_kind_res),
        .o_channel_res  (o_channel_res),
        .o_number_res   (o_number_res),
        .o_value        (o_value)
    );

endmodule

FILE: rtl/core/mcst_ram.sv
module mcst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: rtl/core/mcst_front.sv
module mcst_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clearing,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_command,
    input  logic [7:0]          i_status_byte,
    input  logic [6:0]          i_data_one,
    input  logic [6:0]          i_data_two,
    input  logic [3:0]          i_kind,
    input  logic [4:0]          i_channel,
    input  logic [6:0]          i_number,
    input  logic                i_watch_enable,
    output logic                o_op_valid,
    output mcst_pkg::t_op_item  o_op,
    input  logic                i_pop
);

    localparam int PTR_W = (mcst_pkg::QUEUE_DEPTH > 1) ? $clog2(mcst_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mcst_pkg::QUEUE_DEPTH + 1);

    mcst_pkg::t_op_item r_queue [mcst_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;

    mcst_pkg::t_op_item item;
    logic               keep;
    logic               push;
    logic [4:0]         chan_m1;
    logic               chan_ok;
    logic [3:0]         msg_type;

    assign chan_m1  = i_channel - 5'd1;
    assign chan_ok  = (i_channel != 5'd0) && (i_channel <= 5'(mcst_pkg::CHANNELS));
    assign msg_type = i_status_byte[7:4];

    // Classify the incoming item; items that change nothing are dropped here.
    always_comb begin
        keep      = 1'b0;
        item.op   = mcst_pkg::OP_READ;
        item.ch   = chan_m1[mcst_pkg::CH_W-1:0];
        item.chan = i_channel;
        item.kind = i_kind;
        item.num  = i_number;
        item.val  = i_data_two;
        item.flag = i_watch_enable;
        case (i_command)
            mcst_pkg::CMD_MESSAGE: begin
                item.ch   = i_status_byte[3:0];
                item.chan = {1'b0, i_status_byte[3:0]} + 5'd1;
                item.num  = i_data_one;
                keep      = 1'b1;
                case (msg_type)
                    mcst_pkg::MT_NOTE_ON: begin
                        item.op   = mcst_pkg::OP_NOTE_ON;
                        item.kind = mcst_pkg::KIND_NOTE_ON;
                    end
                    mcst_pkg::MT_NOTE_OFF: begin
                        item.op   = mcst_pkg::OP_NOTE_OFF;
                        item.kind = mcst_pkg::KIND_NOTE_OFF;
                    end
                    mcst_pkg::MT_CONTROL: begin
                        item.op   = mcst_pkg::OP_CONTROL;
                        item.kind = mcst_pkg::KIND_CONTROL;
                    end
                    mcst_pkg::MT_PROGRAM: begin
                        item.op   = mcst_pkg::OP_PROGRAM;
                        item.kind = mcst_pkg::KIND_TRIGGER;
                    end
                    mcst_pkg::MT_BEND: begin
                        item.op   = mcst_pkg::OP_BEND;
                        item.kind = mcst_pkg::KIND_BEND;
                    end
                    default: keep = 1'b0;
                endcase
            end
            mcst_pkg::CMD_WATCH: begin
                item.op = mcst_pkg::OP_WATCH;
                keep    = chan_ok && (i_kind == mcst_pkg::KIND_NOTE_ON ||
                                      i_kind == mcst_pkg::KIND_NOTE_OFF ||
                                      i_kind == mcst_pkg::KIND_CONTROL ||
                                      i_kind == mcst_pkg::KIND_BEND ||
                                      i_kind == mcst_pkg::KIND_TRIGGER);
            end
            mcst_pkg::CMD_READ: begin
                item.op   = mcst_pkg::OP_READ;
                keep      = 1'b1;
                item.flag = chan_ok && (i_kind <= mcst_pkg::KIND_LAST_CTRL) &&
                            (i_kind != mcst_pkg::KIND_TRIGGER);
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_in_ready = (r_cnt != CNT_W'(mcst_pkg::QUEUE_DEPTH)) && !i_clearing;
    assign push       = i_in_valid && o_in_ready && keep;
    assign o_op_valid = (r_cnt != '0);
    assign o_op       = r_queue[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(mcst_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(mcst_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(mcst_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("pop from empty queue");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clearing |-> !o_in_ready)
        else $error("item accepted during table clear");

endmodule

FILE: rtl/core/mcst_back.sv
module mcst_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    output logic                o_clearing,
    input  logic                i_op_valid,
    input  mcst_pkg::t_op_item  i_op,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_ok,
    output logic [3:0]          o_kind_res,
    output logic [4:0]          o_channel_res,
    output logic [6:0]          o_number_res,
    output logic [13:0]         o_value
);

    localparam int AW  = mcst_pkg::TABLE_ADDR_W;
    localparam int DW  = mcst_pkg::DATA_W;
    localparam int VW  = mcst_pkg::VALUE_W;
    localparam int NCH = mcst_pkg::CHANNELS;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_RESP  = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [AW-1:0]      r_clr_addr;
    mcst_pkg::t_op_item r_op;

    logic [VW-1:0] r_last_on   [NCH];
    logic [VW-1:0] r_last_off  [NCH];
    logic [VW-1:0] r_last_ctrl [NCH];
    logic [DW-1:0] r_program   [NCH];
    logic [VW-1:0] r_bend      [NCH];
    logic [NCH-1:0] r_watch_bend;

    logic          clearing;
    logic [AW-1:0] op_addr;
    logic [AW-1:0] waddr;
    logic          watch_wr;
    logic          we_on, we_off, we_ctrl;
    logic          we_w_on, we_w_off, we_w_ctrl, we_w_prog;
    logic [DW-1:0] lvl_wdata;
    logic          watch_wdata;
    logic [DW-1:0] lvl_on_rd, lvl_off_rd, lvl_ctrl_rd;
    logic          w_on_rd, w_off_rd, w_ctrl_rd, w_prog_rd;

    logic          emit;
    logic          res_ok;
    logic [VW-1:0] res_value;
    logic [DW-1:0] res_num;
    logic          load_out;

    assign clearing   = (r_state == S_CLEAR);
    assign o_clearing = clearing;
    assign o_pop      = (r_state == S_IDLE) && i_op_valid;
    assign op_addr    = {i_op.ch, i_op.num};
    assign watch_wr   = o_pop && (i_op.op == mcst_pkg::OP_WATCH);

    // Table writes: the clear sweep writes zero, otherwise the popped operation.
    assign waddr       = clearing ? r_clr_addr : op_addr;
    assign lvl_wdata   = clearing ? '0 : i_op.val;
    assign watch_wdata = clearing ? 1'b0 : i_op.flag;
    assign we_on   = clearing || (o_pop && i_op.op == mcst_pkg::OP_NOTE_ON);
    assign we_off  = clearing || (o_pop && i_op.op == mcst_pkg::OP_NOTE_OFF);
    assign we_ctrl = clearing || (o_pop && i_op.op == mcst_pkg::OP_CONTROL);
    assign we_w_on   = clearing || (watch_wr && i_op.kind == mcst_pkg::KIND_NOTE_ON);
    assign we_w_off  = clearing || (watch_wr && i_op.kind == mcst_pkg::KIND_NOTE_OFF);
    assign we_w_ctrl = clearing || (watch_wr && i_op.kind == mcst_pkg::KIND_CONTROL);
    assign we_w_prog = clearing || (watch_wr && i_op.kind == mcst_pkg::KIND_TRIGGER);

    mcst_ram #(.WIDTH(DW), .DEPTH(mcst_pkg::TABLE_DEPTH)) u_lvl_on (
        .i_clk(i_clk), .i_we(we_on), .i_waddr(waddr), .i_wdata(lvl_wdata),
        .i_re(o_pop), .i_raddr(op_addr), .o_rdata(lvl_on_rd));
    mcst_ram #(.WIDTH(DW), .DEPTH(mcst_pkg::TABLE_DEPTH)) u_lvl_off (
        .i_clk(i_clk), .i_we(we_off), .i_waddr(waddr), .i_wdata(lvl_wdata),
        .i_re(o_pop), .i_raddr(op_addr), .o_rdata(lvl_off_rd));
    mcst_ram #(.WIDTH(DW), .DEPTH(mcst_pkg::TABLE_DEPTH)) u_lvl_ctrl (
        .i_clk(i_clk), .i_we(we_ctrl), .i_waddr(waddr), .i_wdata(lvl_wdata),
        .i_re(o_pop), .i_raddr(op_addr), .o_rdata(lvl_ctrl_rd));
    mcst_ram #(.WIDTH(1), .DEPTH(mcst_pkg::TABLE_DEPTH)) u_watch_on (
        .i_clk(i_clk), .i_we(we_w_on), .i_waddr(waddr), .i_wdata(watch_wdata),
        .i_re(o_pop), .i_raddr(op_addr), .o_rdata(w_on_rd));
    mcst_ram #(.WIDTH(1), .DEPTH(mcst_pkg::TABLE_DEPTH)) u_watch_off (
        .i_clk(i_clk), .i_we(we_w_off), .i_waddr(waddr), .i_wdata(watch_wdata),
        .i_re(o_pop), .i_raddr(op_addr), .o_rdata(w_off_rd));
    mcst_ram #(.WIDTH(1), .DEPTH(mcst_pkg::TABLE_DEPTH)) u_watch_ctrl (
        .i_clk(i_clk), .i_we(we_w_ctrl), .i_waddr(waddr), .i_wdata(watch_wdata),
        .i_re(o_pop), .i_raddr(op_addr), .o_rdata(w_ctrl_rd));
    mcst_ram #(.WIDTH(1), .DEPTH(mcst_pkg::TABLE_DEPTH)) u_watch_prog (
        .i_clk(i_clk), .i_we(we_w_prog), .i_waddr(waddr), .i_wdata(watch_wdata),
        .i_re(o_pop), .i_raddr(op_addr), .o_rdata(w_prog_rd));

    // Result of the operation held in r_op, formed once the table data is back.
    always_comb begin
        emit      = 1'b0;
        res_ok    = 1'b1;
        res_num   = r_op.num;
        res_value = {{DW{1'b0}}, r_op.val};
        case (r_op.op)
            mcst_pkg::OP_NOTE_ON:  emit = w_on_rd;
            mcst_pkg::OP_NOTE_OFF: emit = w_off_rd;
            mcst_pkg::OP_CONTROL:  emit = w_ctrl_rd;
            mcst_pkg::OP_PROGRAM: begin
                emit      = w_prog_rd;
                res_value = '0;
            end
            mcst_pkg::OP_BEND: begin
                emit      = r_watch_bend[r_op.ch];
                res_num   = '0;
                res_value = {r_op.val, r_op.num};
            end
            mcst_pkg::OP_READ: begin
                emit      = 1'b1;
                res_ok    = r_op.flag;
                res_num   = '0;
                res_value = '0;
                if (r_op.flag) begin
                    case (r_op.kind)
                        mcst_pkg::KIND_NOTE_ON: begin
                            res_num   = r_op.num;
                            res_value = {{DW{1'b0}}, lvl_on_rd};
                        end
                        mcst_pkg::KIND_NOTE_OFF: begin
                            res_num   = r_op.num;
                            res_value = {{DW{1'b0}}, lvl_off_rd};
                        end
                        mcst_pkg::KIND_CONTROL: begin
                            res_num   = r_op.num;
                            res_value = {{DW{1'b0}}, lvl_ctrl_rd};
                        end
                        mcst_pkg::KIND_PROGRAM:
                            res_value = {{DW{1'b0}}, r_program[r_op.ch]};
                        mcst_pkg::KIND_BEND:
                            res_value = r_bend[r_op.ch];
                        mcst_pkg::KIND_LAST_ON: begin
                            res_num   = r_last_on[r_op.ch][VW-1:DW];
                            res_value = {{DW{1'b0}}, r_last_on[r_op.ch][DW-1:0]};
                        end
                        mcst_pkg::KIND_LAST_OFF: begin
                            res_num   = r_last_off[r_op.ch][VW-1:DW];
                            res_value = {{DW{1'b0}}, r_last_off[r_op.ch][DW-1:0]};
                        end
                        mcst_pkg::KIND_LAST_CTRL: begin
                            res_num   = r_last_ctrl[r_op.ch][VW-1:DW];
                            res_value = {{DW{1'b0}}, r_last_ctrl[r_op.ch][DW-1:0]};
                        end
                        default: res_ok = 1'b0;
                    endcase
                end
            end
            default: emit = 1'b0;
        endcase
    end

    assign load_out = (r_state == S_RESP) && emit && (!o_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(mcst_pkg::TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_pop && i_op.op != mcst_pkg::OP_WATCH) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!emit || load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_op;
        end
        if (load_out) begin
            o_ok          <= res_ok;
            o_kind_res    <= r_op.kind;
            o_channel_res <= r_op.chan;
            o_number_res  <= res_num;
            o_value       <= res_value;
        end
    end

    // Per-channel registers, cleared directly at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                r_last_on[i]   <= '0;
                r_last_off[i]  <= '0;
                r_last_ctrl[i] <= '0;
                r_program[i]   <= '0;
                r_bend[i]      <= '0;
            end
            r_watch_bend <= '0;
        end else if (o_pop) begin
            case (i_op.op)
                mcst_pkg::OP_NOTE_ON:  r_last_on[i_op.ch]   <= {i_op.num, i_op.val};
                mcst_pkg::OP_NOTE_OFF: r_last_off[i_op.ch]  <= {i_op.num, i_op.val};
                mcst_pkg::OP_CONTROL:  r_last_ctrl[i_op.ch] <= {i_op.num, i_op.val};
                mcst_pkg::OP_PROGRAM:  r_program[i_op.ch]   <= i_op.num;
                mcst_pkg::OP_BEND:     r_bend[i_op.ch]      <= {i_op.val, i_op.num};
                mcst_pkg::OP_WATCH: begin
                    if (i_op.kind == mcst_pkg::KIND_BEND) begin
                        r_watch_bend[i_op.ch] <= i_op.flag;
                    end
                end
                default: r_watch_bend <= r_watch_bend;
            endcase
        end
    end

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_pop)
        else $error("operation taken during table clear");

    a_watch_no_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_op.op == mcst_pkg::OP_WATCH) |=> (r_state == S_IDLE))
        else $error("watch operation entered response state");

    a_resp_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) |-> $past(r_state == S_IDLE || r_state == S_RESP))
        else $error("response state not reached through a pop");

    a_load_in_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_RESP))
        else $error("result loaded outside response state");

endmodule

FILE: dv/mcst_tb_pkg.sv
`timescale 1ns / 1ps

package mcst_tb_pkg;
    import mcst_pkg::*;

    // One result as it leaves the block.
    typedef struct packed {
        logic              ok;
        logic [3:0]        kind;
        logic [4:0]        chan;
        logic [DATA_W-1:0] num;
        logic [VALUE_W-1:0] value;
    } t_midi_result;

    // Shadow copy of the channel state. Each accepted item updates the copy and
    // queues the result it should produce; results from the block are then
    // compared in order against that queue.
    class t_channel_state_mirror;
        bit [DATA_W-1:0]  note_on_vel   [TABLE_DEPTH];
        bit [DATA_W-1:0]  note_off_vel  [TABLE_DEPTH];
        bit [DATA_W-1:0]  control_val   [TABLE_DEPTH];
        bit [VALUE_W-1:0] last_on_pair  [CHANNELS];
        bit [VALUE_W-1:0] last_off_pair [CHANNELS];
        bit [VALUE_W-1:0] last_cc_pair  [CHANNELS];
        bit [DATA_W-1:0]  program_sel   [CHANNELS];
        bit [VALUE_W-1:0] bend_pos      [CHANNELS];
        bit               watch_on      [TABLE_DEPTH];
        bit               watch_off     [TABLE_DEPTH];
        bit               watch_cc      [TABLE_DEPTH];
        bit               watch_prog    [TABLE_DEPTH];
        bit               watch_bend    [CHANNELS];

        t_midi_result expected_results[$];
        int unsigned  mismatches;
        int unsigned  compared;
        int unsigned  notifications;

        // Returns 1 when the item has any effect on state or output.
        function bit absorb_item(input logic [1:0] cmd, input logic [7:0] status,
                                 input logic [6:0] d1, input logic [6:0] d2,
                                 input logic [3:0] kind, input logic [4:0] chan,
                                 input logic [6:0] num, input logic en);
            logic [CH_W-1:0]         ch;
            logic [TABLE_ADDR_W-1:0] idx;
            t_midi_result            res;
            bit                      notify;
            case (cmd)
                CMD_MESSAGE: begin
                    ch = status[3:0];
                    idx = {ch, d1};
                    res.ok = 1'b1;
                    res.chan = {1'b0, ch} + 5'd1;
                    res.num = d1;
                    res.value = VALUE_W'(d2);
                    case (status[7:4])
                        MT_NOTE_ON: begin
                            last_on_pair[ch] = {d1, d2};
                            note_on_vel[idx] = d2;
                            res.kind = KIND_NOTE_ON;
                            notify = watch_on[idx];
                        end
                        MT_NOTE_OFF: begin
                            last_off_pair[ch] = {d1, d2};
                            note_off_vel[idx] = d2;
                            res.kind = KIND_NOTE_OFF;
                            notify = watch_off[idx];
                        end
                        MT_CONTROL: begin
                            last_cc_pair[ch] = {d1, d2};
                            control_val[idx] = d2;
                            res.kind = KIND_CONTROL;
                            notify = watch_cc[idx];
                        end
                        MT_PROGRAM: begin
                            program_sel[ch] = d1;
                            res.kind = KIND_TRIGGER;
                            res.value = '0;
                            notify = watch_prog[idx];
                        end
                        MT_BEND: begin
                            bend_pos[ch] = {d2, d1};
                            res.kind = KIND_BEND;
                            res.num = '0;
                            res.value = {d2, d1};
                            notify = watch_bend[ch];
                        end
                        default: return 1'b0;
                    endcase
                    if (notify) begin
                        expected_results = {expected_results, res};
                        notifications++;
                    end
                    return 1'b1;
                end
                CMD_WATCH: begin
                    if (chan < 1 || chan > CHANNELS)
                        return 1'b0;
                    ch = 4'(chan - 5'd1);
                    idx = {ch, num};
                    case (kind)
                        KIND_NOTE_ON:  watch_on[idx] = en;
                        KIND_NOTE_OFF: watch_off[idx] = en;
                        KIND_CONTROL:  watch_cc[idx] = en;
                        KIND_TRIGGER:  watch_prog[idx] = en;
                        KIND_BEND:     watch_bend[ch] = en;
                        default:       return 1'b0;
                    endcase
                    return 1'b1;
                end
                CMD_READ: begin
                    res.ok = 1'b0;
                    res.kind = kind;
                    res.chan = chan;
                    res.num = '0;
                    res.value = '0;
                    if (chan >= 1 && chan <= CHANNELS) begin
                        ch = 4'(chan - 5'd1);
                        idx = {ch, num};
                        res.ok = 1'b1;
                        case (kind)
                            KIND_NOTE_ON: begin
                                res.num = num;
                                res.value = VALUE_W'(note_on_vel[idx]);
                            end
                            KIND_NOTE_OFF: begin
                                res.num = num;
                                res.value = VALUE_W'(note_off_vel[idx]);
                            end
                            KIND_CONTROL: begin
                                res.num = num;
                                res.value = VALUE_W'(control_val[idx]);
                            end
                            KIND_PROGRAM: res.value = VALUE_W'(program_sel[ch]);
                            KIND_BEND:    res.value = bend_pos[ch];
                            KIND_LAST_ON: begin
                                res.num = last_on_pair[ch][13:7];
                                res.value = VALUE_W'(last_on_pair[ch][6:0]);
                            end
                            KIND_LAST_OFF: begin
                                res.num = last_off_pair[ch][13:7];
                                res.value = VALUE_W'(last_off_pair[ch][6:0]);
                            end
                            KIND_LAST_CTRL: begin
                                res.num = last_cc_pair[ch][13:7];
                                res.value = VALUE_W'(last_cc_pair[ch][6:0]);
                            end
                            default: res.ok = 1'b0;
                        endcase
                    end
                    expected_results = {expected_results, res};
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void field_matches(input string name, input logic [13:0] want,
                                    input logic [13:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_result(input t_midi_result got);
            t_midi_result want;
            compared++;
            if (expected_results.size() == 0) begin
                $error("result with nothing outstanding: ok=%0d kind=%0d chan=%0d num=%0d val=%0d",
                       got.ok, got.kind, got.chan, got.num, got.value);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            field_matches("ok", VALUE_W'(want.ok), VALUE_W'(got.ok));
            field_matches("kind_res", VALUE_W'(want.kind), VALUE_W'(got.kind));
            field_matches("channel_res", VALUE_W'(want.chan), VALUE_W'(got.chan));
            field_matches("number_res", VALUE_W'(want.num), VALUE_W'(got.num));
            field_matches("value", want.value, got.value);
        endfunction

        function void close_out();
            foreach (expected_results[i])
                $error("result never arrived: ok=%0d kind=%0d chan=%0d num=%0d value=%0d",
                       expected_results[i].ok, expected_results[i].kind,
                       expected_results[i].chan, expected_results[i].num,
                       expected_results[i].value);
            mismatches += expected_results.size();
        endfunction
    endclass

endpackage

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mcst_pkg::*;
    import mcst_tb_pkg::*;

    // Codes the block treats as no-ops; the package has no names for them.
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [3:0] MT_SYSTEM   = 4'hF;
    localparam logic [3:0] KIND_UNUSED = 4'd15;

    // Number of input items the whole run aims for.
    localparam int unsigned ITEM_TARGET = 1850;
    // How long the receiver refuses results during the back-pressure phase.
    localparam int unsigned HOLD_CYCLES = 400;
    // Cycles allowed for outstanding results to drain at a pause.
    localparam int unsigned DRAIN_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_command;
    logic [7:0]  i_status_byte;
    logic [6:0]  i_data_one;
    logic [6:0]  i_data_two;
    logic [3:0]  i_kind;
    logic [4:0]  i_channel;
    logic [6:0]  i_number;
    logic        i_watch_enable;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_ok;
    logic [3:0]  o_kind_res;
    logic [4:0]  o_channel_res;
    logic [6:0]  o_number_res;
    logic [13:0] o_value;

    // Percent chance of a sender gap and of a receiver stall on any cycle.
    int unsigned send_gap_pct     = 34;
    int unsigned recv_stall_pct   = 34;
    // Set by the stimulus, counted down by the receiver process.
    int unsigned hold_cycles_left = 0;
    // Items accepted that change state or produce a result.
    int unsigned effective_items  = 0;
    // Every item accepted by the block.
    int unsigned items_sent       = 0;

    t_channel_state_mirror mirror = new();

    midi_channel_state_tracker u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_status_byte  (i_status_byte),
        .i_data_one     (i_data_one),
        .i_data_two     (i_data_two),
        .i_kind         (i_kind),
        .i_channel      (i_channel),
        .i_number       (i_number),
        .i_watch_enable (i_watch_enable),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ok           (o_ok),
        .o_kind_res     (o_kind_res),
        .o_channel_res  (o_channel_res),
        .o_number_res   (o_number_res),
        .o_value        (o_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run,
    // including the table clearing pass after reset.
    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side. The ready line changes on the falling edge. During a hold
    // the receiver refuses every result until hold_cycles_left, counted down
    // here, reaches zero, so the block's queue fills and it has to stall its input.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles_left > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles_left--;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Results are taken on the rising edge, where both handshake lines are
    // stable, and checked against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            mirror.compare_result({o_ok, o_kind_res, o_channel_res, o_number_res, o_value});
    end

    // Offers one item, with random gaps in front of it, and waits until the
    // block takes it. Inputs change only on the falling edge, and valid stays
    // high with the payload unchanged until the handshake completes. Once the
    // item is accepted the shadow state is updated right away, before its result
    // can appear.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] status,
                             input logic [6:0] d1, input logic [6:0] d2,
                             input logic [3:0] kind, input logic [4:0] chan,
                             input logic [6:0] num, input logic en);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_status_byte  <= status;
        i_data_one     <= d1;
        i_data_two     <= d2;
        i_kind         <= kind;
        i_channel      <= chan;
        i_number       <= num;
        i_watch_enable <= en;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        items_sent++;
        if (mirror.absorb_item(cmd, status, d1, d2, kind, chan, num, en))
            effective_items++;
    endtask

    // Drops valid and waits, within a limit, until every predicted result has
    // been seen. Anything still missing afterwards is reported at the end.
    task automatic wait_for_drain();
        int unsigned waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (mirror.expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // Builds one random item. Most items are well-formed messages, watches and
    // reads aimed at a few busy channels and numbers, so that watched
    // addresses are hit often and reads return values that were written.
    // Every field starts fully random, so the fields an item does not use
    // still toggle, and about one item in ten is left as pure noise: unused
    // commands, unknown message types, bad channels and unsupported kinds.
    task automatic send_random_item();
        logic [1:0] cmd;
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic [3:0] kind;
        logic [4:0] chan;
        logic [6:0] num;
        logic       en;
        logic [3:0] ch_idx;
        logic [6:0] hot_num;
        logic [3:0] mtype;
        int unsigned pick;

        cmd    = 2'($urandom);
        status = 8'($urandom);
        d1     = 7'($urandom);
        d2     = 7'($urandom);
        kind   = 4'($urandom);
        chan   = 5'($urandom);
        num    = 7'($urandom);
        en     = 1'($urandom);

        case ($urandom_range(0, 4))
            0:       ch_idx = 4'd0;
            1:       ch_idx = 4'd15;
            2:       ch_idx = 4'd9;
            default: ch_idx = 4'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       hot_num = 7'd0;
            1:       hot_num = 7'd127;
            2:       hot_num = 7'd60;
            default: hot_num = 7'($urandom);
        endcase

        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            cmd = CMD_MESSAGE;
            case ($urandom_range(0, 10))
                0, 1:    mtype = MT_NOTE_ON;
                2, 3:    mtype = MT_NOTE_OFF;
                4, 5:    mtype = MT_CONTROL;
                6, 7:    mtype = MT_PROGRAM;
                8, 9:    mtype = MT_BEND;
                default: mtype = 4'($urandom);
            endcase
            status = {mtype, ch_idx};
            d1 = hot_num;
        end else if (pick < 56) begin
            cmd = CMD_WATCH;
            case ($urandom_range(0, 7))
                0, 1:    kind = KIND_NOTE_ON;
                2:       kind = KIND_NOTE_OFF;
                3:       kind = KIND_CONTROL;
                4:       kind = KIND_TRIGGER;
                5:       kind = KIND_BEND;
                default: ;
            endcase
            if ($urandom_range(0, 9) != 0)
                chan = {1'b0, ch_idx} + 5'd1;
            num = hot_num;
            en = ($urandom_range(0, 9) < 7);
        end else if (pick < 90) begin
            cmd = CMD_READ;
            if ($urandom_range(0, 9) != 0)
                kind = 4'($urandom_range(0, KIND_LAST_CTRL));
            if ($urandom_range(0, 9) != 0)
                chan = {1'b0, ch_idx} + 5'd1;
            num = hot_num;
        end
        send_item(cmd, status, d1, d2, kind, chan, num, en);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = CMD_MESSAGE;
        i_status_byte  = '0;
        i_data_one     = '0;
        i_data_two     = '0;
        i_kind         = KIND_NOTE_ON;
        i_channel      = '0;
        i_number       = '0;
        i_watch_enable = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // The block clears its tables for a while after reset; the first
        // handshake simply waits for that to finish.

        // Directed part. A read right after reset must return zero.
        send_item(CMD_READ, 8'h00, 7'd0, 7'd0, KIND_NOTE_ON, 5'd1, 7'd0, 1'b0);
        // A note-on with velocity 0 is still a note-on and notifies as one.
        send_item(CMD_WATCH, 8'h00, 7'd0, 7'd0, KIND_NOTE_ON, 5'd1, 7'd127, 1'b1);
        send_item(CMD_MESSAGE, {MT_NOTE_ON, 4'd0}, 7'd127, 7'd0, KIND_NOTE_ON, 5'd0,
                  7'd0, 1'b0);
        send_item(CMD_MESSAGE, {MT_NOTE_ON, 4'd0}, 7'd127, 7'd127, KIND_NOTE_ON, 5'd0,
                  7'd0, 1'b0);
        // Note-off and controller on the last channel at both number extremes.
        send_item(CMD_WATCH, 8'h00, 7'd0, 7'd0, KIND_NOTE_OFF, 5'd16, 7'd0, 1'b1);
        send_item(CMD_MESSAGE, {MT_NOTE_OFF, 4'd15}, 7'd0, 7'd127, KIND_NOTE_ON, 5'd0,
                  7'd0, 1'b0);
        send_item(CMD_WATCH, 8'h00, 7'd0, 7'd0, KIND_CONTROL, 5'd16, 7'd127, 1'b1);
        send_item(CMD_MESSAGE, {MT_CONTROL, 4'd15}, 7'd127, 7'd64, KIND_NOTE_ON, 5'd0,
                  7'd0, 1'b0);
        // A program change notifies as a trigger with a zero value and ignores
        // its second data byte.
        send_item(CMD_WATCH, 8'h00, 7'd0, 7'd0, KIND_TRIGGER, 5'd1, 7'd127, 1'b1);
        send_item(CMD_MESSAGE, {MT_PROGRAM, 4'd0}, 7'd127, 7'd127, KIND_NOTE_ON, 5'd0,
                  7'd0, 1'b0);
        // Full-scale pitch bend.
        send_item(CMD_WATCH, 8'h00, 7'd0, 7'd0, KIND_BEND, 5'd16, 7'd0, 1'b1);
        send_item(CMD_MESSAGE, {MT_BEND, 4'd15}, 7'd127, 7'd127, KIND_NOTE_ON, 5'd0,
                  7'd0, 1'b0);
        // Reads of the per-channel registers and the last pairs.
        send_item(CMD_READ, 8'h00, 7'd0, 7'd0, KIND_PROGRAM, 5'd1, 7'd0, 1'b0);
        send_item(CMD_READ, 8'h00, 7'd0, 7'd0, KIND_BEND, 5'd16, 7'd0, 1'b0);
        send_item(CMD_READ, 8'h00, 7'd0, 7'd0, KIND_LAST_ON, 5'd1, 7'd0, 1'b0);
        send_item(CMD_READ, 8'h00, 7'd0, 7'd0, KIND_LAST_OFF, 5'd16, 7'd0, 1'b0);
        send_item(CMD_READ, 8'h00, 7'd0, 7'd0, KIND_LAST_CTRL, 5'd16, 7'd0, 1'b0);
        // Unsupported read kinds and out-of-range channels answer with ok low.
        send_item(CMD_READ, 8'h00, 7'd0, 7'd0, KIND_TRIGGER, 5'd1, 7'd5, 1'b0);
        send_item(CMD_READ, 8'h00, 7'd0, 7'd0, KIND_UNUSED, 5'd16, 7'd5, 1'b0);
        send_item(CMD_READ, 8'h00, 7'd0, 7'd0, KIND_NOTE_ON, 5'd0, 7'd127, 1'b0);
        send_item(CMD_READ, 8'h00, 7'd0, 7'd0, KIND_CONTROL, 5'd31, 7'd127, 1'b0);
        // Items the block must ignore: a watch on a bad channel or of a kind
        // without watch bits, the unused command and an unknown message type.
        send_item(CMD_WATCH, 8'h00, 7'd0, 7'd0, KIND_NOTE_ON, 5'd17, 7'd127, 1'b0);
        send_item(CMD_WATCH, 8'h00, 7'd0, 7'd0, KIND_PROGRAM, 5'd1, 7'd127, 1'b1);
        send_item(CMD_UNUSED, {MT_NOTE_ON, 4'd0}, 7'd127, 7'd1, KIND_NOTE_ON, 5'd1,
                  7'd127, 1'b1);
        send_item(CMD_MESSAGE, {MT_SYSTEM, 4'd0}, 7'd127, 7'd1, KIND_NOTE_ON, 5'd1,
                  7'd127, 1'b1);
        // Clearing the watch bit silences the address again.
        send_item(CMD_WATCH, 8'h00, 7'd0, 7'd0, KIND_NOTE_ON, 5'd1, 7'd127, 1'b0);
        send_item(CMD_MESSAGE, {MT_NOTE_ON, 4'd0}, 7'd127, 7'd3, KIND_NOTE_ON, 5'd0,
                  7'd0, 1'b0);

        // Random traffic with gaps and stalls on both sides.
        while (items_sent < 700)
            send_random_item();

        // Back-pressure: the receiver refuses results for a long stretch while
        // the sender keeps offering items, so the queue fills and the input
        // stalls. Afterwards the sender waits until everything has drained.
        hold_cycles_left = HOLD_CYCLES;
        repeat (60)
            send_random_item();
        wait_for_drain();

        // A stretch at full rate with no gaps and no stalls.
        send_gap_pct = 0;
        recv_stall_pct = 0;
        while (items_sent < 1300)
            send_random_item();

        send_gap_pct = 34;
        recv_stall_pct = 34;
        while (items_sent < ITEM_TARGET)
            send_random_item();

        // Let the last results come out, then keep watching for anything spurious
        // the block might still produce.
        wait_for_drain();
        repeat (10) @(posedge i_clk);
        mirror.close_out();

        $display("Sent %0d items, %0d with an effect; checked %0d results.",
                 items_sent, effective_items, mirror.compared);
        $display("Notifications seen: %0d, mismatches found: %0d.",
                 mirror.notifications, mirror.mismatches);
        if (mirror.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
